>>> rtl/core/execute_stage_alu_flags_branch_assert.svh
// Assertion macros used by the execute stage checker.
`ifndef EXECUTE_STAGE_ALU_FLAGS_BRANCH_ASSERT_SVH
`define EXECUTE_STAGE_ALU_FLAGS_BRANCH_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define ESAFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define ESAFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/esafb_pkg.sv
// Package: opcodes, memory op codes, flag codes and defaults of the execute stage.
`default_nettype none

package esafb_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned OUT_WIDTH      = 32;
  localparam int unsigned ADDR_WIDTH     = 16;
  localparam int unsigned PTR_STEP       = 4;

  typedef enum logic [4:0] {
    OP_NOP    = 5'd0,
    OP_HALT   = 5'd1,
    OP_MOVC   = 5'd2,
    OP_ADD    = 5'd3,
    OP_SUB    = 5'd4,
    OP_MUL    = 5'd5,
    OP_AND    = 5'd6,
    OP_OR     = 5'd7,
    OP_XOR    = 5'd8,
    OP_ADDL   = 5'd9,
    OP_SUBL   = 5'd10,
    OP_CMP    = 5'd11,
    OP_CML    = 5'd12,
    OP_BZ     = 5'd13,
    OP_BNZ    = 5'd14,
    OP_BP     = 5'd15,
    OP_BNP    = 5'd16,
    OP_BN     = 5'd17,
    OP_BNN    = 5'd18,
    OP_JUMP   = 5'd19,
    OP_JALR   = 5'd20,
    OP_LOAD   = 5'd21,
    OP_LOADP  = 5'd22,
    OP_STORE  = 5'd23,
    OP_STOREP = 5'd24
  } op_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_READ  = 2'd1,
    MEM_WRITE = 2'd2
  } mem_op_e;

  // Flag vector: bit2 P, bit1 N, bit0 Z
  localparam logic [2:0] FLAGS_NONE = 3'b000;
  localparam logic [2:0] FLAG_P     = 3'b100;
  localparam logic [2:0] FLAG_N     = 3'b010;
  localparam logic [2:0] FLAG_Z     = 3'b001;

endpackage

`default_nettype wire

>>> rtl/core/execute_stage_alu_flags_branch.sv
// Execute stage: ALU, P/N/Z condition flags, branch resolution and memory request.
`default_nettype none

// Executes one decoded instruction per item. An item enters an input register,
// passes through one level of ALU / address / branch logic, and lands in a
// result register; it takes one item per cycle unless out_ready_i stalls the
// pipe. The P/N/Z flags live in a register updated as an item moves into the
// result register; the next item's branch test sees them with no bubble, which
// is what holds the rate at one item per cycle. The widest path is the
// DATA_WIDTH x DATA_WIDTH multiply (low half only) feeding the zero/sign test.
// Ready propagates back through both stages: while a finished result waits
// downstream the input register still takes one item if it is empty, so a full
// pipe holds two items. Arithmetic is DATA_WIDTH-bit two's complement and wraps; operands are
// sign-extended from 32 bits, and each 32-bit result port shows the low 32 bits
// of the DATA_WIDTH-bit value. Unused result fields read zero, loads report a
// zero dest_value (data comes later from memory), and opcodes 25 to 31 behave
// as NOP. Flags reset to all clear, so BZ/BP/BN are not taken until a flag is set.
module execute_stage_alu_flags_branch #(
  parameter int unsigned DATA_WIDTH = esafb_pkg::DATA_WIDTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // instruction channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic        [4:0]  operation_i,
  input  wire logic signed [31:0] src1_value_i,
  input  wire logic signed [31:0] src2_value_i,
  input  wire logic signed [31:0] literal_i,
  input  wire logic        [15:0] instr_address_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    dest_write_o,
  output logic signed [31:0]      dest_value_o,
  output logic                    pointer_write_o,
  output logic signed [31:0]      pointer_value_o,
  output logic        [1:0]       mem_op_o,
  output logic signed [31:0]      mem_address_o,
  output logic signed [31:0]      mem_data_o,
  output logic                    branch_taken_o,
  output logic                    redirect_o,
  output logic signed [31:0]      redirect_target_o,
  output logic        [2:0]       flags_out_o
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned OW = esafb_pkg::OUT_WIDTH;

  // Exactly one flag from a DW-bit result.
  function automatic logic [2:0] flags_of(input logic [DW-1:0] r);
    logic [2:0] f;
    if (r == '0) begin
      f = esafb_pkg::FLAG_Z;
    end else if (r[DW-1]) begin
      f = esafb_pkg::FLAG_N;
    end else begin
      f = esafb_pkg::FLAG_P;
    end
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake: each stage advances when its downstream slot frees up
  // ---------------------------------------------------------------------------
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_adv, in_adv;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_ready_o = in_adv;

  always_comb begin
    in_valid_d  = in_adv ? in_valid_i : in_valid_q;
    out_valid_d = out_adv ? in_valid_q : out_valid_q;
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic        [4:0]  op_q;
  logic signed [31:0] src1_q;
  logic signed [31:0] src2_q;
  logic signed [31:0] lit_q;
  logic        [15:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_adv) begin
      op_q   <= operation_i;
      src1_q <= src1_value_i;
      src2_q <= src2_value_i;
      lit_q  <= literal_i;
      addr_q <= instr_address_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute logic
  // ---------------------------------------------------------------------------
  logic [DW-1:0] a, b, lit, pc;
  logic [DW-1:0] alu_res;
  logic          alu_op;
  logic [DW-1:0] dv, pv, maddr, mdata, tgt;
  logic          dw, pw, taken, redir;
  logic [1:0]    mop;
  logic [2:0]    flags_q, flags_d;

  // Sign-extend (or truncate) the 32-bit operands into the datapath width.
  assign a   = DW'(src1_q);
  assign b   = DW'(src2_q);
  assign lit = DW'(lit_q);
  assign pc  = DW'(addr_q);

  always_comb begin
    alu_res = '0;
    alu_op  = 1'b0;
    dw      = 1'b0;
    dv      = '0;
    pw      = 1'b0;
    pv      = '0;
    mop     = esafb_pkg::MEM_NONE;
    maddr   = '0;
    mdata   = '0;
    taken   = 1'b0;
    redir   = 1'b0;
    tgt     = '0;
    flags_d = flags_q;

    case (op_q)
      esafb_pkg::OP_MOVC: begin
        dw = 1'b1;
        dv = lit;
      end
      esafb_pkg::OP_ADD: begin
        alu_res = a + b;
        alu_op  = 1'b1;
      end
      esafb_pkg::OP_SUB: begin
        alu_res = a - b;
        alu_op  = 1'b1;
      end
      esafb_pkg::OP_MUL: begin
        alu_res = a * b;
        alu_op  = 1'b1;
      end
      esafb_pkg::OP_AND: begin
        alu_res = a & b;
        alu_op  = 1'b1;
      end
      esafb_pkg::OP_OR: begin
        alu_res = a | b;
        alu_op  = 1'b1;
      end
      esafb_pkg::OP_XOR: begin
        alu_res = a ^ b;
        alu_op  = 1'b1;
      end
      esafb_pkg::OP_ADDL: begin
        alu_res = a + lit;
        alu_op  = 1'b1;
      end
      esafb_pkg::OP_SUBL: begin
        alu_res = a - lit;
        alu_op  = 1'b1;
      end
      esafb_pkg::OP_CMP: flags_d = flags_of(a - b);
      esafb_pkg::OP_CML: flags_d = flags_of(a - lit);
      esafb_pkg::OP_BZ:  taken = |(flags_q & esafb_pkg::FLAG_Z);
      esafb_pkg::OP_BNZ: taken = ~|(flags_q & esafb_pkg::FLAG_Z);
      esafb_pkg::OP_BP:  taken = |(flags_q & esafb_pkg::FLAG_P);
      esafb_pkg::OP_BNP: taken = ~|(flags_q & esafb_pkg::FLAG_P);
      esafb_pkg::OP_BN:  taken = |(flags_q & esafb_pkg::FLAG_N);
      esafb_pkg::OP_BNN: taken = ~|(flags_q & esafb_pkg::FLAG_N);
      esafb_pkg::OP_JUMP: begin
        redir = 1'b1;
        tgt   = a + lit;
      end
      esafb_pkg::OP_JALR: begin
        redir = 1'b1;
        tgt   = a + lit;
        dw    = 1'b1;
        dv    = pc + DW'(esafb_pkg::PTR_STEP);
      end
      esafb_pkg::OP_LOAD: begin
        dw    = 1'b1;
        mop   = esafb_pkg::MEM_READ;
        maddr = a + lit;
      end
      esafb_pkg::OP_LOADP: begin
        dw    = 1'b1;
        mop   = esafb_pkg::MEM_READ;
        maddr = a + lit;
        pw    = 1'b1;
        pv    = a + DW'(esafb_pkg::PTR_STEP);
      end
      esafb_pkg::OP_STORE: begin
        mop   = esafb_pkg::MEM_WRITE;
        maddr = b + lit;
        mdata = a;
      end
      esafb_pkg::OP_STOREP: begin
        mop   = esafb_pkg::MEM_WRITE;
        maddr = b + lit;
        mdata = a;
        pw    = 1'b1;
        pv    = b + DW'(esafb_pkg::PTR_STEP);
      end
      default: ; // NOP, HALT and unused codes
    endcase

    // Register-register and register-literal ALU ops write back and set flags
    if (alu_op) begin
      dw      = 1'b1;
      dv      = alu_res;
      flags_d = flags_of(alu_res);
    end

    // Taken conditional branch redirects relative to its own address
    if (taken) begin
      redir = 1'b1;
      tgt   = pc + lit;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers: valids and condition flags
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= esafb_pkg::FLAGS_NONE;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (in_valid_q && out_adv) begin
        flags_q <= flags_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic        res_dw_q, res_pw_q, res_taken_q, res_redir_q;
  logic [1:0]  res_mop_q;
  logic [31:0] res_dv_q, res_pv_q, res_maddr_q, res_mdata_q, res_tgt_q;
  logic [2:0]  res_flags_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_q && out_adv) begin
      res_dw_q    <= dw;
      res_dv_q    <= OW'(dv);
      res_pw_q    <= pw;
      res_pv_q    <= OW'(pv);
      res_mop_q   <= mop;
      res_maddr_q <= OW'(maddr);
      res_mdata_q <= OW'(mdata);
      res_taken_q <= taken;
      res_redir_q <= redir;
      res_tgt_q   <= OW'(tgt);
      res_flags_q <= flags_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign dest_write_o      = res_dw_q;
  assign dest_value_o      = res_dv_q;
  assign pointer_write_o   = res_pw_q;
  assign pointer_value_o   = res_pv_q;
  assign mem_op_o          = res_mop_q;
  assign mem_address_o     = res_maddr_q;
  assign mem_data_o        = res_mdata_q;
  assign branch_taken_o    = res_taken_q;
  assign redirect_o        = res_redir_q;
  assign redirect_target_o = res_tgt_q;
  assign flags_out_o       = res_flags_q;

endmodule

`default_nettype wire

>>> rtl/core/esafb_checker.sv
// Port-level checker for the execute stage, bound to the execute stage module.
`default_nettype none

`include "execute_stage_alu_flags_branch_assert.svh"

module esafb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        pointer_write_o,
  input wire logic [1:0]  mem_op_o,
  input wire logic        branch_taken_o,
  input wire logic        redirect_o,
  input wire logic [2:0]  flags_out_o
);

  // a stalled result keeps its control fields
  `ESAFB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(redirect_o) && $stable(mem_op_o) && $stable(flags_out_o),
    "result changed while stalled")

  // at most one condition flag is ever set
  `ESAFB_ASSERT_NOW(a_flags_onehot, out_valid_o, $onehot0(flags_out_o),
    "more than one flag set")

  // a taken branch always redirects fetch
  `ESAFB_ASSERT_NOW(a_taken_redir, out_valid_o && branch_taken_o, redirect_o,
    "taken branch without redirect")

  // pointer update only comes with a memory access
  `ESAFB_ASSERT_NOW(a_ptr_mem, out_valid_o && pointer_write_o,
    mem_op_o == esafb_pkg::MEM_READ || mem_op_o == esafb_pkg::MEM_WRITE,
    "pointer write without memory op")

endmodule

bind execute_stage_alu_flags_branch esafb_checker u_esafb_checker (.*);

`default_nettype wire

>>> test/execute_stage_alu_flags_branch_test.sv
// Testbench for the execute stage: random and directed instructions checked against a predictor.
`timescale 1ns / 1ps

module execute_stage_alu_flags_branch_test;

  localparam int unsigned DW        = esafb_pkg::DATA_WIDTH_DEF;
  localparam int          N_RANDOM  = 700;
  localparam int          LIMIT     = 200000;  // cycles
  localparam int          MAX_SHOWN = 10;

  // Opcodes past the last defined one; the stage treats them as NOP.
  localparam logic [4:0] OP_SPARE_FIRST = 5'd25;
  localparam logic [4:0] OP_SPARE_LAST  = 5'd31;

  // One decoded instruction as presented on the input channel.
  typedef struct packed {
    logic [4:0]  operation;
    logic [31:0] src1;
    logic [31:0] src2;
    logic [31:0] literal;
    logic [15:0] addr;
  } instr_t;

  // Everything the stage reports for one instruction.
  typedef struct packed {
    logic        dest_write;
    logic [31:0] dest_value;
    logic        pointer_write;
    logic [31:0] pointer_value;
    logic [1:0]  mem_op;
    logic [31:0] mem_address;
    logic [31:0] mem_data;
    logic        branch_taken;
    logic        redirect;
    logic [31:0] redirect_target;
    logic [2:0]  flags;
  } exec_result_t;

  function automatic string describe(exec_result_t r);
    return $sformatf({"dw=%0b dv=%h pw=%0b pv=%h mop=%0d ma=%h md=%h bt=%0b rd=%0b ",
                      "tg=%h flags=%b"},
                     r.dest_write, r.dest_value, r.pointer_write, r.pointer_value,
                     r.mem_op, r.mem_address, r.mem_data, r.branch_taken, r.redirect,
                     r.redirect_target, r.flags);
  endfunction

  // Scoreboard: keeps its own copy of the P/N/Z flags, works out the result of
  // every accepted instruction in order and matches results against them.
  class exec_scoreboard;
    exec_result_t pending_results[$];
    logic [2:0]   flags;
    logic [31:0]  ops_seen;
    int unsigned  noted, checked, mismatches, taken, flag_writes;

    function new();
      flags = esafb_pkg::FLAGS_NONE;
      ops_seen = '0;
      noted = 0; checked = 0; mismatches = 0; taken = 0; flag_writes = 0;
    endfunction

    function logic [2:0] flag_code(logic [DW-1:0] r);
      if (r == '0) return esafb_pkg::FLAG_Z;
      if (r[DW-1]) return esafb_pkg::FLAG_N;
      return esafb_pkg::FLAG_P;
    endfunction

    // Executes one instruction on the local flag copy.
    function exec_result_t execute(instr_t it);
      exec_result_t   res;
      logic [DW-1:0]  a, b, lit, addr, r;
      logic           alu;
      logic [2:0]     f;
      res  = '0;
      a    = DW'($signed(it.src1));
      b    = DW'($signed(it.src2));
      lit  = DW'($signed(it.literal));
      addr = DW'(it.addr);
      r    = '0;
      alu  = 1'b0;
      f    = flags;
      case (it.operation)
        esafb_pkg::OP_MOVC: begin
          res.dest_write = 1'b1;
          res.dest_value = lit[31:0];
        end
        esafb_pkg::OP_ADD:  begin r = a + b;   alu = 1'b1; end
        esafb_pkg::OP_SUB:  begin r = a - b;   alu = 1'b1; end
        esafb_pkg::OP_MUL:  begin r = a * b;   alu = 1'b1; end
        esafb_pkg::OP_AND:  begin r = a & b;   alu = 1'b1; end
        esafb_pkg::OP_OR:   begin r = a | b;   alu = 1'b1; end
        esafb_pkg::OP_XOR:  begin r = a ^ b;   alu = 1'b1; end
        esafb_pkg::OP_ADDL: begin r = a + lit; alu = 1'b1; end
        esafb_pkg::OP_SUBL: begin r = a - lit; alu = 1'b1; end
        esafb_pkg::OP_CMP:  begin flags = flag_code(a - b);   flag_writes++; end
        esafb_pkg::OP_CML:  begin flags = flag_code(a - lit); flag_writes++; end
        esafb_pkg::OP_BZ:   res.branch_taken = (f & esafb_pkg::FLAG_Z) != 0;
        esafb_pkg::OP_BNZ:  res.branch_taken = (f & esafb_pkg::FLAG_Z) == 0;
        esafb_pkg::OP_BP:   res.branch_taken = (f & esafb_pkg::FLAG_P) != 0;
        esafb_pkg::OP_BNP:  res.branch_taken = (f & esafb_pkg::FLAG_P) == 0;
        esafb_pkg::OP_BN:   res.branch_taken = (f & esafb_pkg::FLAG_N) != 0;
        esafb_pkg::OP_BNN:  res.branch_taken = (f & esafb_pkg::FLAG_N) == 0;
        esafb_pkg::OP_JUMP: begin
          res.redirect = 1'b1;
          res.redirect_target = 32'(a + lit);
        end
        esafb_pkg::OP_JALR: begin
          res.redirect = 1'b1;
          res.redirect_target = 32'(a + lit);
          res.dest_write = 1'b1;
          res.dest_value = 32'(addr + DW'(esafb_pkg::PTR_STEP));
        end
        esafb_pkg::OP_LOAD, esafb_pkg::OP_LOADP: begin
          // loaded data arrives later, so dest_value stays zero
          res.dest_write  = 1'b1;
          res.mem_op      = esafb_pkg::MEM_READ;
          res.mem_address = 32'(a + lit);
          if (it.operation == esafb_pkg::OP_LOADP) begin
            res.pointer_write = 1'b1;
            res.pointer_value = 32'(a + DW'(esafb_pkg::PTR_STEP));
          end
        end
        esafb_pkg::OP_STORE, esafb_pkg::OP_STOREP: begin
          res.mem_op      = esafb_pkg::MEM_WRITE;
          res.mem_address = 32'(b + lit);
          res.mem_data    = 32'(a);
          if (it.operation == esafb_pkg::OP_STOREP) begin
            res.pointer_write = 1'b1;
            res.pointer_value = 32'(b + DW'(esafb_pkg::PTR_STEP));
          end
        end
        default: ;  // NOP, HALT and spare codes
      endcase
      if (alu) begin
        res.dest_write = 1'b1;
        res.dest_value = 32'(r);
        flags = flag_code(r);
        flag_writes++;
      end
      if (res.branch_taken) begin
        res.redirect = 1'b1;
        res.redirect_target = 32'(addr + lit);
        taken++;
      end
      res.flags = flags;
      return res;
    endfunction

    function void note_instr(instr_t it);
      pending_results.push_back(execute(it));
      ops_seen[it.operation] = 1'b1;
      noted++;
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t exp;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: %s", describe(got));
        return;
      end
      exp = pending_results.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("result %0d mismatch", checked);
          $display("  expected %s", describe(exp));
          $display("  actual   %s", describe(got));
        end
      end
      checked++;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  // Clock, reset and block inputs; all known from time zero.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        out_ready = 1'b0;
  logic [4:0]  operation = esafb_pkg::OP_NOP;
  logic [31:0] src1_value = '0;
  logic [31:0] src2_value = '0;
  logic [31:0] literal = '0;
  logic [15:0] instr_address = '0;

  logic        in_ready, out_valid;
  logic        dest_write, pointer_write, branch_taken, redirect;
  logic [31:0] dest_value, pointer_value, mem_address, mem_data, redirect_target;
  logic [1:0]  mem_op;
  logic [2:0]  flags_out;

  exec_scoreboard sb;
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  execute_stage_alu_flags_branch #(.DATA_WIDTH(DW)) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .operation_i      (operation),
    .src1_value_i     (src1_value),
    .src2_value_i     (src2_value),
    .literal_i        (literal),
    .instr_address_i  (instr_address),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .dest_write_o     (dest_write),
    .dest_value_o     (dest_value),
    .pointer_write_o  (pointer_write),
    .pointer_value_o  (pointer_value),
    .mem_op_o         (mem_op),
    .mem_address_o    (mem_address),
    .mem_data_o       (mem_data),
    .branch_taken_o   (branch_taken),
    .redirect_o       (redirect),
    .redirect_target_o(redirect_target),
    .flags_out_o      (flags_out)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Monitor both channels, then pick the next ready value. Inputs are noted
  // before outputs are checked so a same-edge result never races its item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready)
        sb.note_instr({operation, src1_value, src2_value, literal, instr_address});
      if (out_valid && out_ready)
        sb.check_result({dest_write, dest_value, pointer_write, pointer_value, mem_op,
                         mem_address, mem_data, branch_taken, redirect, redirect_target,
                         flags_out});
    end
    // Receiver walks through stretches of differing back-pressure.
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;                        // no stalls
      1:       out_ready <= 1'($urandom_range(0, 1));    // coin toss
      2:       out_ready <= ($urandom_range(0, 3) == 0); // mostly stalled
      default: out_ready <= (cycles % 3 == 0);           // fixed cadence
    endcase
  end

  // Operand values weighted toward the corners of the 32-bit range.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return 32'($signed($urandom_range(0, 31)) - 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t mk(logic [4:0] op, logic [31:0] s1, logic [31:0] s2,
                                logic [31:0] lit, logic [15:0] addr);
    return '{operation: op, src1: s1, src2: s2, literal: lit, addr: addr};
  endfunction

  function automatic instr_t random_instr(logic [4:0] op);
    instr_t it;
    it = mk(op, pick_word(), pick_word(), pick_word(), 16'($urandom));
    // Equal operands give zero results for SUB, XOR, SUBL, CMP and CML.
    if ($urandom_range(0, 3) == 0) begin
      it.src2 = it.src1;
      it.literal = it.src1;
    end
    return it;
  endfunction

  // Present one item, hold it until accepted, then idle for a random gap, possibly none, if the burst is over.
  task automatic push_instr(input instr_t it);
    int gap;
    operation     <= it.operation;
    src1_value    <= it.src1;
    src2_value    <= it.src2;
    literal       <= it.literal;
    instr_address <= it.addr;
    in_valid      <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    int sent;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: branches on cleared flags, then each operation at its corners.
    push_instr(mk(esafb_pkg::OP_BZ,  '0, '0, 32'd16, 16'd100));  // no flag set: not taken
    push_instr(mk(esafb_pkg::OP_BP,  '0, '0, 32'd16, 16'd100));
    push_instr(mk(esafb_pkg::OP_BN,  '0, '0, 32'd16, 16'd100));
    push_instr(mk(esafb_pkg::OP_BNZ, '0, '0, 32'hFFFF_FFF8, 16'd0));  // taken, wraps below 0
    push_instr(mk(esafb_pkg::OP_BNP, '0, '0, 32'h7FFF_FFFF, 16'hFFFF));
    push_instr(mk(esafb_pkg::OP_BNN, '0, '0, 32'h8000_0000, 16'd4));
    push_instr(mk(esafb_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1, '0, '0));  // overflow to negative
    push_instr(mk(esafb_pkg::OP_SUB, 32'd5, 32'd5, '0, '0));          // zero
    push_instr(mk(esafb_pkg::OP_BZ,  '0, '0, 32'd8, 16'h1234));
    push_instr(mk(esafb_pkg::OP_MUL, 32'h0001_0000, 32'h0001_0000, '0, '0));  // wraps to zero
    push_instr(mk(esafb_pkg::OP_AND, 32'hFFFF_FFFF, 32'h8000_0000, '0, '0));
    push_instr(mk(esafb_pkg::OP_OR,  32'h0000_0000, 32'h0000_0000, '0, '0));
    push_instr(mk(esafb_pkg::OP_XOR, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '0, '0));
    push_instr(mk(esafb_pkg::OP_ADDL, 32'd1, '0, 32'd2, '0));
    push_instr(mk(esafb_pkg::OP_SUBL, 32'h8000_0000, '0, 32'd1, '0));  // wraps to positive
    push_instr(mk(esafb_pkg::OP_CMP, 32'hDEAD_BEEF, 32'hDEAD_BEEF, '0, '0));
    push_instr(mk(esafb_pkg::OP_CML, 32'h8000_0000, '0, 32'h7FFF_FFFF, '0));
    push_instr(mk(esafb_pkg::OP_MOVC, 32'hFFFF_FFFF, '0, 32'h8000_0000, '0));
    push_instr(mk(esafb_pkg::OP_JUMP, 32'h7FFF_FFFF, '0, 32'd1, '0));
    push_instr(mk(esafb_pkg::OP_JALR, 32'h1000, '0, 32'hFFFF_FFFC, 16'hFFFF));  // link > 16b
    push_instr(mk(esafb_pkg::OP_LOAD, 32'h100, 32'h55, 32'hFFFF_FFFF, '0));
    push_instr(mk(esafb_pkg::OP_LOADP, 32'hFFFF_FFFC, '0, 32'd8, '0));  // pointer wraps to 0
    push_instr(mk(esafb_pkg::OP_STORE, 32'hCAFE_F00D, 32'h7FFF_FFFF, 32'd1, '0));
    push_instr(mk(esafb_pkg::OP_STOREP, 32'h1234_5678, 32'h7FFF_FFFC, '0, '0));
    push_instr(mk(esafb_pkg::OP_HALT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  16'hFFFF));
    push_instr(mk(esafb_pkg::OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  16'hFFFF));
    push_instr(mk(OP_SPARE_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));

    // Random: mostly a flag-setting op followed by a conditional branch,
    // the rest any opcode at all, spare codes included.
    sent = 0;
    while (sent < N_RANDOM) begin
      if ($urandom_range(0, 9) < 6) begin
        push_instr(random_instr(5'($urandom_range(esafb_pkg::OP_ADD, esafb_pkg::OP_CML))));
        push_instr(random_instr(5'($urandom_range(esafb_pkg::OP_BZ, esafb_pkg::OP_BNN))));
        sent += 2;
      end else if ($urandom_range(0, 15) == 0) begin
        push_instr(random_instr(5'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST))));
        sent++;
      end else begin
        push_instr(random_instr(5'($urandom_range(esafb_pkg::OP_NOP,
                                                  esafb_pkg::OP_STOREP))));
        sent++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);  // catch any stray result

    $display("ran %0d instructions over %0d of 32 opcodes, %0d results checked",
             sb.noted, $countones(sb.ops_seen), sb.checked);
    $display("%0d flag updates, %0d branches taken, %0d mismatches",
             sb.flag_writes, sb.taken, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/esafb_pkg.sv
rtl/core/execute_stage_alu_flags_branch.sv
rtl/core/esafb_checker.sv
test/execute_stage_alu_flags_branch_test.sv
